@@ sv/acos_pkg.sv @@
// ----------------------------------------------------------------------------
// acos_pkg - shared constants for the arccosine pipeline
// Default formats, Q32 polynomial coefficients, pi in Q62, clamp limit.
// ----------------------------------------------------------------------------
package acos_pkg;

    // default input / output fraction bits
    localparam int IN_FRAC_BITS_DEF  = 15;
    localparam int OUT_FRAC_BITS_DEF = 14;

    // polynomial coefficients, unsigned Q32, rounded to nearest
    localparam logic [63:0] K3_Q32_W =
        ((64'd187293 << 32) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] K2_Q32_W =
        ((64'd742610 << 32) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] K1_Q32_W =
        ((64'd2121144 << 32) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] K0_Q32_W =
        ((64'd15707288 << 32) + 64'd5000000) / 64'd10000000;

    localparam logic [32:0] K3_Q32 = K3_Q32_W[32:0];
    localparam logic [32:0] K2_Q32 = K2_Q32_W[32:0];
    localparam logic [32:0] K1_Q32 = K1_Q32_W[32:0];
    localparam logic [32:0] K0_Q32 = K0_Q32_W[32:0];

    // pi, Q62
    localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

    // clamp limit 0.999999 as a ratio
    localparam logic [63:0] LIM_NUM = 64'd999999;
    localparam logic [63:0] LIM_DEN = 64'd1000000;

    // radicand is Q62, root Q31: 32 result bits, two per stage
    localparam int SQ_STAGES = 16;

endpackage

@@ sv/arccos_poly_sqrt.sv @@
// ----------------------------------------------------------------------------
// arccos_poly_sqrt - pipelined fixed-point arccosine
// Cubic polynomial in |x| times sqrt(1-|x|), reflected for negative x.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_tvalid/i_tready/i_tdata) carries one cosine sample x,
//   signed Q1.IN_FRAC_BITS. Master channel (o_tvalid/o_tready/o_tdata)
//   carries acos(x), unsigned Q2.OUT_FRAC_BITS radians (pi is the largest code).
//   A transfer happens at a rising edge with tvalid and tready both high.
// Pipeline: 21 register stages from the input transfer to o_tvalid: input,
//   16 root stages (two root bits each), root rounding, final product,
//   product rounding, output register.
// Throughput: one transfer per clock while o_tready stays high. The Horner
//   multiplies run in the first three root stages, one 32x32 multiply per stage.
// Stall: each stage moves when the one after it is empty or moving, so a
//   stalled receiver freezes only the filled tail; empty slots upstream keep
//   filling and i_tready drops only once every stage holds an item.
// Reset: i_rst_n low (synchronous) empties all stages; no other state.
// ----------------------------------------------------------------------------
module arccos_poly_sqrt #(
    parameter int IN_FRAC_BITS  = acos_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = acos_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // slave side
    input  logic                                        i_tvalid,
    output logic                                        i_tready,
    input  logic [((IN_FRAC_BITS + 1 + 7) / 8) * 8 - 1:0]  i_tdata,  // [0+]: sample_in
    // master side
    output logic                                        o_tvalid,
    input  logic                                        o_tready,
    output logic [((OUT_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] o_tdata   // [0+]: angle_out
);

    localparam int SW = IN_FRAC_BITS + 1;            // sample width
    localparam int AW = OUT_FRAC_BITS + 2;           // angle width
    localparam int OW = ((AW + 7) / 8) * 8;          // output tdata width

    // stage map
    localparam int ST_SQ_FIRST = 1;
    localparam int ST_SQ_LAST  = ST_SQ_FIRST + acos_pkg::SQ_STAGES - 1;
    localparam int ST_SQ_RND   = ST_SQ_LAST + 1;
    localparam int ST_PROD     = ST_SQ_RND + 1;
    localparam int ST_RND      = ST_PROD + 1;
    localparam int ST_OUT      = ST_RND + 1;
    localparam int NSTG        = ST_OUT + 1;

    // largest |x| code that is not clamped
    localparam logic [63:0] LIM_MAG_W =
        (acos_pkg::LIM_NUM << IN_FRAC_BITS) / acos_pkg::LIM_DEN;
    localparam logic [SW-1:0] LIM_MAG = LIM_MAG_W[SW-1:0];

    // pi rounded into the output format
    localparam logic [63:0] PI_OUT_W =
        (acos_pkg::PI_Q62 + (64'd1 << (61 - OUT_FRAC_BITS))) >> (62 - OUT_FRAC_BITS);
    localparam logic [AW-1:0] PI_OUT = PI_OUT_W[AW-1:0];

    typedef struct packed {
        logic          neg;    // x negative
        logic          clamp;  // |x| beyond limit
        logic [31:0]   a;      // |x|, Q0.32
        logic [32:0]   t;      // Horner partial, Q32
        logic [62:0]   rem;    // root remainder
        logic [62:0]   res;    // root partial; rounded root after ST_SQ_RND
        logic [63:0]   prod;   // product, then rounded magnitude
        logic [AW-1:0] ang;    // final angle
    } t_stage;

    t_stage [NSTG-1:0] r_stg;
    t_stage [NSTG-1:0] n_stg;
    logic   [NSTG-1:0] r_vld;
    logic   [NSTG-1:0] rdy;

    // Q32 product, rounded to nearest
    function automatic logic [31:0] mul_q32(input logic [31:0] u, input logic [31:0] v);
        logic [63:0] p;
        p = u * v;
        p = p + 64'h0000_0000_8000_0000;
        return p[63:32];
    endfunction

    // ready chain: a stage takes a new item when empty or when it drains
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || o_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    // per-stage datapath
    always_comb begin
        logic [SW-1:0] raw;
        logic [SW-1:0] mag;
        logic [32:0]   s;
        logic [63:0]   sum;
        logic [62:0]   bitv;
        logic [64:0]   pw;
        logic [64:0]   rs;
        logic [AW-1:0] rmag;
        int            e;

        // input stage: magnitude, clamp test, root radicand
        raw = i_tdata[SW-1:0];
        mag = raw[SW-1] ? (~raw + SW'(1)) : raw;
        s   = 33'h1_0000_0000;
        n_stg[0]       = '0;
        n_stg[0].neg   = raw[SW-1];
        n_stg[0].clamp = (mag > LIM_MAG);
        n_stg[0].a     = 32'(mag[SW-2:0]) << (32 - IN_FRAC_BITS);
        s              = s - {1'b0, n_stg[0].a};
        n_stg[0].rem   = {s, 30'd0};
        n_stg[0].res   = '0;

        for (int k = 1; k < NSTG; k++) begin
            n_stg[k] = r_stg[k-1];

            // Horner, one coefficient per stage
            if (k == ST_SQ_FIRST) begin
                n_stg[k].t = acos_pkg::K2_Q32
                           - {1'b0, mul_q32(acos_pkg::K3_Q32[31:0], r_stg[k-1].a)};
            end
            if (k == ST_SQ_FIRST + 1) begin
                n_stg[k].t = acos_pkg::K1_Q32
                           - {1'b0, mul_q32(r_stg[k-1].t[31:0], r_stg[k-1].a)};
            end
            if (k == ST_SQ_FIRST + 2) begin
                n_stg[k].t = acos_pkg::K0_Q32
                           - {1'b0, mul_q32(r_stg[k-1].t[31:0], r_stg[k-1].a)};
            end

            // digit-by-digit root, two bits per stage
            if (k >= ST_SQ_FIRST && k <= ST_SQ_LAST) begin
                for (int j = 0; j < 2; j++) begin
                    e    = 62 - 2 * (2 * (k - ST_SQ_FIRST) + j);
                    bitv = 63'd1 << e;
                    sum  = {1'b0, n_stg[k].res} + {1'b0, bitv};
                    if ({1'b0, n_stg[k].rem} >= sum) begin
                        n_stg[k].rem = n_stg[k].rem - sum[62:0];
                        n_stg[k].res = (n_stg[k].res >> 1) + bitv;
                    end else begin
                        n_stg[k].res = n_stg[k].res >> 1;
                    end
                end
            end

            // round root to nearest
            if (k == ST_SQ_RND) begin
                n_stg[k].res = (r_stg[k-1].rem > r_stg[k-1].res)
                             ? r_stg[k-1].res + 63'd1 : r_stg[k-1].res;
            end

            // polynomial times root, Q63
            if (k == ST_PROD) begin
                pw = r_stg[k-1].t * r_stg[k-1].res[31:0];
                n_stg[k].prod = pw[63:0];
            end

            // round into output format
            if (k == ST_RND) begin
                rs = {1'b0, r_stg[k-1].prod} + (65'd1 << (62 - OUT_FRAC_BITS));
                rs = rs >> (63 - OUT_FRAC_BITS);
                n_stg[k].prod = rs[63:0];
            end

            // saturate, reflect, clamp
            if (k == ST_OUT) begin
                rmag = (r_stg[k-1].prod > 64'(PI_OUT)) ? PI_OUT : r_stg[k-1].prod[AW-1:0];
                if (r_stg[k-1].clamp) begin
                    n_stg[k].ang = r_stg[k-1].neg ? PI_OUT : '0;
                end else begin
                    n_stg[k].ang = r_stg[k-1].neg ? (PI_OUT - rmag) : rmag;
                end
            end
        end
    end

    // stage registers; payload unreset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_tready = rdy[0];
    assign o_tvalid = r_vld[NSTG-1];
    assign o_tdata  = OW'(r_stg[NSTG-1].ang);

endmodule

@@ test/arccos_poly_sqrt_tb.sv @@
// ----------------------------------------------------------------------------
// arccos_poly_sqrt_tb - self-checking bench for the arccosine pipeline
// Streams Q1.15 cosine samples through the slave channel and checks every
// Q2.14 angle on the master channel against a bit-exact model of the fixed
// point algorithm, under varying source idle and sink backpressure.
// ----------------------------------------------------------------------------
module arccos_poly_sqrt_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W        = 16;          // sample_in, Q1.15
    localparam int OUT_W       = 16;          // angle_out, Q2.14
    localparam int RAND_ITEMS  = 1600;
    localparam int PHASE_ITEMS = RAND_ITEMS / 4;
    localparam int HOLD_CYCLES = 80;          // long sink hold-off
    localparam int DRAIN_WAIT  = 40;          // end-of-test wait for stray output
    localparam int CYCLE_LIMIT = 400000;

    // polynomial coefficients, unsigned Q32, rounded to nearest
    localparam logic [63:0] C_CUBE   = ((64'd187293 << 32) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] C_SQUARE = ((64'd742610 << 32) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] C_LINEAR = ((64'd2121144 << 32) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] C_CONST  = ((64'd15707288 << 32) + 64'd5000000) / 64'd10000000;

    // pi in Q62, rounded to nearest in Q2.14 -> 51472
    localparam logic [63:0] PI_Q62_BITS = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] PI_ANGLE    = (PI_Q62_BITS + (64'd1 << 47)) >> 48;

    typedef struct {
        logic [IN_W-1:0]  sample;
        logic [OUT_W-1:0] angle;
    } t_angle_entry;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts acos for each accepted sample, checks results in
    // order. The block keeps no state, so each prediction stands alone.
    // ------------------------------------------------------------------------
    class acos_scoreboard;
        t_angle_entry pending_angles[$];
        int unsigned  faults;

        // rounded Q32 product
        static function logic [63:0] q32_mul(logic [63:0] u, logic [63:0] v);
            return (u * v + (64'd1 << 31)) >> 32;
        endfunction

        // integer square root, rounded to nearest
        static function logic [63:0] round_root(logic [63:0] radicand);
            logic [63:0] acc;
            logic [63:0] probe;
            logic [63:0] left;
            acc   = 64'd0;
            probe = 64'd1 << 62;
            left  = radicand;
            while (probe > left)
                probe = probe >> 2;
            while (probe != 64'd0) begin
                if (left >= acc + probe) begin
                    left = left - (acc + probe);
                    acc  = (acc >> 1) + probe;
                end else begin
                    acc = acc >> 1;
                end
                probe = probe >> 2;
            end
            if (left > acc)
                acc = acc + 64'd1;
            return acc;
        endfunction

        static function logic [OUT_W-1:0] acos_angle(logic [IN_W-1:0] x);
            logic        is_neg;
            logic [63:0] absx;
            logic [63:0] xq32;
            logic [63:0] h1;
            logic [63:0] h2;
            logic [63:0] h3;
            logic [63:0] gap;
            logic [63:0] rt;
            logic [63:0] full;
            logic [63:0] mag_out;
            logic [63:0] ang;
            is_neg = x[IN_W-1];
            absx   = is_neg ? (64'd1 << IN_W) - {48'd0, x} : {48'd0, x};
            // |x| > 0.999999 clamps to the end points
            if (absx * 64'd1000000 > (64'd999999 << (IN_W - 1)))
                return is_neg ? PI_ANGLE[OUT_W-1:0] : '0;
            xq32    = absx << (33 - IN_W);
            h1      = C_SQUARE - q32_mul(C_CUBE, xq32);
            h2      = C_LINEAR - q32_mul(h1, xq32);
            h3      = C_CONST - q32_mul(h2, xq32);
            gap     = (64'd1 << 32) - xq32;
            rt      = round_root(gap << 30);
            full    = h3 * rt;                       // Q63
            mag_out = (full + (64'd1 << 48)) >> 49;  // round into Q.14
            if (mag_out > PI_ANGLE)
                mag_out = PI_ANGLE;
            ang = is_neg ? (PI_ANGLE - mag_out) : mag_out;
            return ang[OUT_W-1:0];
        endfunction

        function void note_sample(logic [IN_W-1:0] x);
            t_angle_entry e;
            e.sample = x;
            e.angle  = acos_angle(x);
            pending_angles.push_back(e);
        endfunction

        function void check_angle(logic [OUT_W-1:0] y);
            t_angle_entry e;
            if (pending_angles.size() == 0) begin
                faults++;
                $display("%0t: unexpected angle transfer, expected none, got %0d", $time, y);
                return;
            end
            e = pending_angles.pop_front();
            if (y !== e.angle) begin
                faults++;
                $display("%0t: angle for sample %0d: expected %0d, got %0d",
                         $time, $signed(e.sample), e.angle, y);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             i_tvalid = 1'b0;
    logic             i_tready;
    logic [IN_W-1:0]  i_tdata  = '0;     // [15:0]: sample_in
    logic             o_tvalid;
    logic             o_tready = 1'b0;
    logic [OUT_W-1:0] o_tdata;           // [15:0]: angle_out

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    arccos_poly_sqrt u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .i_tready (i_tready),
        .i_tdata  (i_tdata),
        .o_tvalid (o_tvalid),
        .o_tready (o_tready),
        .o_tdata  (o_tdata)
    );

    acos_scoreboard sb;

    // idle / stall controls, set per phase by the main sequence
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // long hold request: main toggles, sink process counts the hold itself
    logic        hold_req  = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------------
    // Sink: random backpressure, plus one long hold to fill the pipeline
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            o_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            o_tready  <= 1'b0;
        end else begin
            o_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every transfer on either side goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_tvalid && i_tready)
                sb.note_sample(i_tdata);
            if (o_tvalid && o_tready)
                sb.check_angle(o_tdata);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("arccos_poly_sqrt: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Source tasks
    // ------------------------------------------------------------------------

    // offer one sample, with optional idle cycles first; returns after the
    // transfer edge, tvalid still high so back-to-back items need no dip
    task automatic send_sample(input logic [IN_W-1:0] x);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= x;
        @(posedge i_clk);
        while (!i_tready)
            @(posedge i_clk);
    endtask

    // source goes quiet until every expected angle is back
    task automatic drain_angles();
        i_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_angles.size() != 0)
            @(posedge i_clk);
    endtask

    // random sample: mostly full range, some near +/-1 (clamp and the steep
    // root region), some near zero
    task automatic send_random();
        int unsigned     pick;
        int unsigned     mag;
        logic [IN_W-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            v = IN_W'($urandom_range(0, 65535));
        end else begin
            mag = (pick <= 7) ? $urandom_range(32640, 32768) : $urandom_range(0, 255);
            v   = mag[IN_W-1:0];
            if ($urandom_range(0, 1) == 1 || mag == 32768)
                v = -v;
        end
        send_sample(v);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [IN_W-1:0] corner[$];
        sb = new;
        corner = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8001, 16'h8000,
                   16'h4000, 16'hC000, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00,
                   16'h7FBC, 16'h8044, 16'h7FFE, 16'h8002, 16'h5A82, 16'hA57E};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, +/-1 and the -1.0 clamp, half, alternating bits
        foreach (corner[k])
            send_sample(corner[k]);
        drain_angles();

        // phase 1: no idling; long sink hold early on so the input stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= ~hold_req;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
        drain_angles();

        // phase 2: source idle most of the time
        send_idle_pct = 63;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
        drain_angles();

        // phase 3: sink stalling most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
        drain_angles();

        // phase 4: light idling on both sides
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
        drain_angles();

        // let any stray output show up
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.faults == 0 && sb.pending_angles.size() == 0) begin
            $display("arccos_poly_sqrt: match");
        end else begin
            $display("arccos_poly_sqrt: mismatch");
        end
        $finish;
    end

endmodule
